@@ rtl/ghash_pkg.sv @@
// shared types and constants of the ghash accumulator
package ghash_pkg;

    localparam int BLOCK_BITS     = 128;
    localparam int BLOCK_BYTES    = 16;
    localparam int HALF_BITS      = 64;
    localparam int COUNT_BITS     = 5;
    localparam int DIGIT_BITS_DEF = 8;

    // reduction byte of x^128 + x^7 + x^2 + x + 1, reflected order
    localparam logic [7:0] POLY_BYTE = 8'he1;

    localparam logic CFG_KEY_HI = 1'b0;
    localparam logic CFG_KEY_LO = 1'b1;

    typedef enum logic [1:0] {
        MODE_AAD   = 2'd0,
        MODE_TEXT  = 2'd1,
        MODE_FINAL = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_PUSH
    } t_state;

    // handshake between control and multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

@@ rtl/ghash_mul.sv @@
// digit-serial gf(2^128) multiplier, DIGIT_BITS bits of x per cycle
module ghash_mul #(
    parameter int DIGIT_BITS = ghash_pkg::DIGIT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ghash_pkg::BLOCK_BITS-1:0] i_x,
    input  logic [ghash_pkg::BLOCK_BITS-1:0] i_h,
    output ghash_pkg::t_mul_status          o_status,
    output logic [ghash_pkg::BLOCK_BITS-1:0] o_z
);

    localparam int NSTEP = (ghash_pkg::BLOCK_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int CNT_W = $clog2(NSTEP);

    logic [ghash_pkg::BLOCK_BITS-1:0] r_x, r_v, r_z;
    logic [ghash_pkg::BLOCK_BITS-1:0] n_x, n_v, n_z;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_busy, r_done;
    logic                             last_step;

    assign last_step = (r_cnt == CNT_W'(NSTEP - 1));

    // one digit of x: DIGIT_BITS shift-and-add steps
    always_comb begin
        n_x = r_x;
        n_v = r_v;
        n_z = r_z;
        for (int b = 0; b < DIGIT_BITS; b++) begin
            if (n_x[ghash_pkg::BLOCK_BITS-1]) begin
                n_z = n_z ^ n_v;
            end
            n_x = {n_x[ghash_pkg::BLOCK_BITS-2:0], 1'b0};
            if (n_v[0]) begin
                n_v = {1'b0, n_v[ghash_pkg::BLOCK_BITS-1:1]};
                n_v[ghash_pkg::BLOCK_BITS-1 -: 8] = n_v[ghash_pkg::BLOCK_BITS-1 -: 8]
                                                    ^ ghash_pkg::POLY_BYTE;
            end else begin
                n_v = {1'b0, n_v[ghash_pkg::BLOCK_BITS-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_v <= i_h;
            r_z <= '0;
        end else if (r_busy) begin
            r_x <= n_x;
            r_v <= n_v;
            r_z <= n_z;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_z           = r_z;

endmodule

@@ rtl/ghash_accumulator.sv @@
// GHASH accumulator top level: control, state registers and stream ports
//
// Each word on the input stream is an absorb (additional data or ciphertext),
// a finalize or a clear, and gives exactly one result word. Absorb and finalize
// run a GF(2^128) multiply by the key that consumes DIGIT_BITS bits of the
// operand per cycle. An item passes through the multiply state until the
// multiplier's done flag and then the push state, which waits until the output
// register is free or being read, before the next word is taken. A clear or an
// absorb with zero bytes skips the multiply and goes straight to the push state.
// The result sits in an output register, so the next word is taken while an
// earlier result still waits. The user writes the key registers through the
// config port only while the block idles; the block does not enforce this.
module ghash_accumulator #(
    parameter int DIGIT_BITS = ghash_pkg::DIGIT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write port
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic [63:0]   i_cfg_data,
    // input words
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // block_hi, block_lo, byte_count, zero pad
    input  logic [1:0]    s_axis_tuser,   // mode
    // result words
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // hash_hi, hash_lo
    output logic          m_axis_tuser    // is_final
);

    localparam int BB = ghash_pkg::BLOCK_BITS;
    localparam int HB = ghash_pkg::HALF_BITS;

    ghash_pkg::t_state      r_state, n_state;
    ghash_pkg::t_mode       in_mode;
    ghash_pkg::t_mul_status mul_st;

    logic [HB-1:0]  r_key_hi, r_key_lo;
    logic [BB-1:0]  r_acc;
    logic [HB-1:0]  r_aad_bits, r_text_bits;
    logic           r_use_mul, r_upd_acc, r_fin;
    logic           r_out_valid;
    logic [BB-1:0]  r_out_data;
    logic           r_out_fin;

    logic [HB-1:0]  in_hi, in_lo;
    logic [ghash_pkg::COUNT_BITS-1:0] in_cnt, cnt_sat;
    logic [BB-1:0]  byte_mask, mul_x, mul_z;
    logic [HB-1:0]  add_bits;
    logic           accept, is_absorb, need_mul, mul_start, push_en;

    assign in_hi   = s_axis_tdata[63:0];
    assign in_lo   = s_axis_tdata[127:64];
    assign in_cnt  = s_axis_tdata[132:128];
    assign in_mode = ghash_pkg::t_mode'(s_axis_tuser);

    assign cnt_sat  = (in_cnt > ghash_pkg::COUNT_BITS'(ghash_pkg::BLOCK_BYTES))
                      ? ghash_pkg::COUNT_BITS'(ghash_pkg::BLOCK_BYTES) : in_cnt;
    assign add_bits = {{(HB-ghash_pkg::COUNT_BITS-3){1'b0}}, cnt_sat, 3'b000};

    // byte 0 is the top byte of the block
    always_comb begin
        for (int i = 0; i < ghash_pkg::BLOCK_BYTES; i++) begin
            byte_mask[BB-1-8*i -: 8] = (ghash_pkg::COUNT_BITS'(i) < cnt_sat) ? 8'hff : 8'h00;
        end
    end

    assign is_absorb = (in_mode == ghash_pkg::MODE_AAD) || (in_mode == ghash_pkg::MODE_TEXT);
    assign need_mul  = (is_absorb && (cnt_sat != '0)) || (in_mode == ghash_pkg::MODE_FINAL);
    assign mul_x     = (in_mode == ghash_pkg::MODE_FINAL)
                       ? (r_acc ^ {r_aad_bits, r_text_bits})
                       : (r_acc ^ ({in_hi, in_lo} & byte_mask));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ghash_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = need_mul ? ghash_pkg::ST_MUL : ghash_pkg::ST_PUSH;
                end
            end
            ghash_pkg::ST_MUL: begin
                if (mul_st.done) begin
                    n_state = ghash_pkg::ST_PUSH;
                end
            end
            ghash_pkg::ST_PUSH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ghash_pkg::ST_IDLE;
                end
            end
            default: n_state = ghash_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        push_en       = 1'b0;
        unique case (r_state)
            ghash_pkg::ST_IDLE: s_axis_tready = 1'b1;
            ghash_pkg::ST_MUL:  ;
            ghash_pkg::ST_PUSH: push_en = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign mul_start = accept && need_mul;

    ghash_mul #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_x      (mul_x),
        .i_h      ({r_key_hi, r_key_lo}),
        .o_status (mul_st),
        .o_z      (mul_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ghash_pkg::ST_IDLE;
            r_key_hi    <= '0;
            r_key_lo    <= '0;
            r_acc       <= '0;
            r_aad_bits  <= '0;
            r_text_bits <= '0;
            r_use_mul   <= 1'b0;
            r_upd_acc   <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == ghash_pkg::CFG_KEY_HI) begin
                    r_key_hi <= i_cfg_data;
                end else begin
                    r_key_lo <= i_cfg_data;
                end
            end
            if (accept) begin
                r_use_mul <= need_mul;
                r_upd_acc <= need_mul && is_absorb;
                r_fin     <= (in_mode == ghash_pkg::MODE_FINAL);
                case (in_mode)
                    ghash_pkg::MODE_AAD: begin
                        r_aad_bits <= r_aad_bits + add_bits;
                    end
                    ghash_pkg::MODE_TEXT: begin
                        r_text_bits <= r_text_bits + add_bits;
                    end
                    ghash_pkg::MODE_CLEAR: begin
                        r_acc       <= '0;
                        r_aad_bits  <= '0;
                        r_text_bits <= '0;
                    end
                    default: ;
                endcase
            end
            if (push_en && r_upd_acc) begin
                r_acc <= mul_z;
            end
            if (push_en) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_out_data <= r_use_mul ? mul_z : r_acc;
            r_out_fin  <= r_fin;
        end
    end

    assign m_axis_tvalid        = r_out_valid;
    assign m_axis_tdata[63:0]   = r_out_data[BB-1:HB];
    assign m_axis_tdata[127:64] = r_out_data[HB-1:0];
    assign m_axis_tuser         = r_out_fin;

    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !mul_st.busy)
        else $error("input taken while multiplier busy");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_st.done |-> (r_state == ghash_pkg::ST_MUL))
        else $error("multiply finished outside multiply state");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_mode == ghash_pkg::MODE_CLEAR))
            |=> ((r_acc == '0) && (r_aad_bits == '0) && (r_text_bits == '0)))
        else $error("clear left state behind");

    a_final_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && r_fin) |=> $stable(r_acc))
        else $error("finalize changed the accumulator");

endmodule
